// ===== rtl/core/graph_dfs_adjacency_matrix_assert.svh =====
// Assertion macros shared by the checker of the depth-first search block.
`ifndef GRAPH_DFS_ADJACENCY_MATRIX_ASSERT_SVH
`define GRAPH_DFS_ADJACENCY_MATRIX_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define GDFS_ASSERT_RST(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define GDFS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ===== rtl/core/gdfs_pkg.sv =====
// Shared constants, types and controller/datapath interface of the DFS block.
`default_nettype none

package gdfs_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VIDX_W       = 6;
  localparam int CNT_W        = 7;
  localparam int LABEL_W      = 8;
  localparam int IN_USER_W    = 2;
  localparam int IN_DATA_W    = 24;
  localparam int OUT_DATA_W   = 16;

  typedef logic [VIDX_W-1:0]       vidx_t;
  typedef logic [LABEL_W-1:0]      label_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [MAX_VERTICES-1:0] row_t;

  typedef enum logic [IN_USER_W-1:0] {
    MODE_CLEAR    = 2'd0,
    MODE_EDGE     = 2'd1,
    MODE_LABEL    = 2'd2,
    MODE_TRAVERSE = 2'd3
  } mode_e;

  // Commands from the controller, at most one walk step per cycle
  typedef struct packed {
    logic clear_adj;
    logic edge_start;
    logic edge_wr_a;
    logic edge_wr_b;
    logic label_wr;
    logic trav_start;
    logic root_take;
    logic emit;
    logic cand_take;
    logic pop;
    logic pop_load;
  } dp_cmd_t;

  // Status back to the controller
  typedef struct packed {
    mode_e mode;
    logic  edge_ok;
    logic  label_ok;
    logic  root_found;
    logic  cand_found;
    logic  depth_one;
    logic  out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/graph_dfs_adjacency_matrix.sv =====
// Top level: depth-first preorder over an adjacency bit matrix.
//
//  channel  dir  handshake                    payload
//  s_axis   in   s_axis_tvalid/s_axis_tready  tuser mode, tdata vertices and label
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata index and label, tlast final vertex
//  cfg      in   cfg_valid_i/cfg_ready_o      vertex count, always ready
//
// Clear edges and set label finish in idle; add edge does a row read-modify-write on each end.
// A traversal holds the input after its beat until the walk ends: take and emit per vertex,
// scan and pop load per backtrack (only the scan when the stack empties), one final root
// scan, paced by the registered adjacency read.
// Reset: rows and labels read as zero through per-entry valid bits, no clearing pass.
// The walk holds in its emit step while the output register waits for its beat to go.
`default_nettype none

module graph_dfs_adjacency_matrix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [5:0] first_vertex, [11:6] second_vertex, [19:12] label, [23:20] zero
  input  logic [gdfs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [gdfs_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [5:0] vertex_index, [13:6] vertex_label, [15:14] zero
  output logic [gdfs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gdfs_pkg::CNT_W-1:0]      cfg_data_i
);
  import gdfs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gdfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gdfs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/core/gdfs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gdfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/gdfs_ctrl.sv =====
// Sequencer for matrix updates and the depth-first walk.
`default_nettype none

module gdfs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gdfs_pkg::dp_sts_t sts_i,
  output gdfs_pkg::dp_cmd_t cmd_o
);
  import gdfs_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EDGE_A = 7'b0000010,
    S_EDGE_B = 7'b0000100,
    S_ROOT   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_POP    = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (sts_i.mode)
            MODE_CLEAR: cmd_o.clear_adj = 1'b1;
            MODE_EDGE: begin
              if (sts_i.edge_ok) begin
                cmd_o.edge_start = 1'b1;
                state_d          = S_EDGE_A;
              end
            end
            MODE_LABEL: cmd_o.label_wr = sts_i.label_ok;
            MODE_TRAVERSE: begin
              cmd_o.trav_start = 1'b1;
              state_d          = S_ROOT;
            end
          endcase
        end
      end
      S_EDGE_A: begin
        cmd_o.edge_wr_a = 1'b1;
        state_d         = S_EDGE_B;
      end
      S_EDGE_B: begin
        cmd_o.edge_wr_b = 1'b1;
        state_d         = S_IDLE;
      end
      S_ROOT: begin
        if (sts_i.root_found) begin
          cmd_o.root_take = 1'b1;
          state_d         = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        // hold until the output register can take the beat
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.cand_found) begin
          cmd_o.cand_take = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = sts_i.depth_one ? S_ROOT : S_POP;
        end
      end
      S_POP: begin
        cmd_o.pop_load = 1'b1;
        state_d        = S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gdfs_datapath.sv =====
// Adjacency, label and stack memories, visited marks and the output register.
`default_nettype none

module gdfs_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [gdfs_pkg::IN_DATA_W-1:0]      in_data_i,
  input  logic [gdfs_pkg::IN_USER_W-1:0]      in_user_i,
  input  logic                                cfg_valid_i,
  input  logic [gdfs_pkg::CNT_W-1:0]          cfg_data_i,
  input  gdfs_pkg::dp_cmd_t                   cmd_i,
  output gdfs_pkg::dp_sts_t                   sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [gdfs_pkg::OUT_DATA_W-1:0]     out_data_o,
  output logic                                out_last_o
);
  import gdfs_pkg::*;

  function automatic vidx_t lowest_idx(row_t x);
    vidx_t k;
    k = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (x[i]) k = VIDX_W'(i);
    end
    return k;
  endfunction

  function automatic row_t bit_of(vidx_t v);
    return row_t'(1) << v;
  endfunction

  vidx_t  in_first, in_second;
  label_t in_label;

  cnt_t   vcount_q, n_act, depth_q, emit_cnt_q;
  row_t   adj_vld_q, lbl_vld_q, visited_q, act_mask;
  vidx_t  a_q, b_q, emit_idx_q;
  logic   adj_rvld_q, lbl_rvld_q;
  logic   out_valid_q, out_last_q;
  vidx_t  out_idx_q;
  label_t out_lbl_q;

  row_t   root_cand, adj_row, nbr_cand;
  vidx_t  root_idx, nx_idx;
  logic   out_free;

  logic   adj_we, adj_re;
  vidx_t  adj_waddr, adj_raddr;
  row_t   adj_wdata, adj_rdata;
  logic   lbl_re;
  vidx_t  lbl_raddr;
  label_t lbl_rdata, lbl_val;
  logic   stk_we, stk_re;
  vidx_t  stk_waddr, stk_wdata, stk_raddr, stk_rdata;

  assign in_first  = in_data_i[VIDX_W-1:0];
  assign in_second = in_data_i[2*VIDX_W-1:VIDX_W];
  assign in_label  = in_data_i[2*VIDX_W+LABEL_W-1:2*VIDX_W];

  assign n_act = (vcount_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vcount_q;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      act_mask[i] = (CNT_W'(i) < n_act);
    end
  end

  assign root_cand = act_mask & ~visited_q;
  assign root_idx  = lowest_idx(root_cand);
  assign adj_row   = adj_rvld_q ? adj_rdata : '0;
  assign nbr_cand  = adj_row & act_mask & ~visited_q;
  assign nx_idx    = lowest_idx(nbr_cand);
  assign lbl_val   = lbl_rvld_q ? lbl_rdata : '0;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.mode       = mode_e'(in_user_i);
    sts_o.edge_ok    = ({1'b0, in_first} < n_act) && ({1'b0, in_second} < n_act);
    sts_o.label_ok   = ({1'b0, in_first} < n_act);
    sts_o.root_found = |root_cand;
    sts_o.cand_found = |nbr_cand;
    sts_o.depth_one  = (depth_q == CNT_W'(1));
    sts_o.out_free   = out_free;
  end

  // Adjacency rows: read-modify-write for edges, at most one row read per walk step
  assign adj_we    = cmd_i.edge_wr_a || cmd_i.edge_wr_b;
  assign adj_waddr = cmd_i.edge_wr_b ? b_q : a_q;
  assign adj_wdata = adj_row | (cmd_i.edge_wr_b ? bit_of(a_q) : bit_of(b_q));
  assign adj_re    = cmd_i.edge_start || cmd_i.edge_wr_a || cmd_i.root_take ||
                     cmd_i.cand_take || cmd_i.pop_load;

  always_comb begin
    priority if (cmd_i.edge_wr_a) begin
      adj_raddr = b_q;
    end else if (cmd_i.root_take) begin
      adj_raddr = root_idx;
    end else if (cmd_i.cand_take) begin
      adj_raddr = nx_idx;
    end else if (cmd_i.pop_load) begin
      adj_raddr = stk_rdata;
    end else begin
      adj_raddr = in_first;
    end
  end

  assign lbl_re    = cmd_i.root_take || cmd_i.cand_take;
  assign lbl_raddr = cmd_i.cand_take ? nx_idx : root_idx;

  assign stk_we    = cmd_i.root_take || cmd_i.cand_take;
  assign stk_waddr = cmd_i.cand_take ? depth_q[VIDX_W-1:0] : '0;
  assign stk_wdata = cmd_i.cand_take ? nx_idx : root_idx;
  assign stk_re    = cmd_i.pop && (depth_q != CNT_W'(1));
  assign stk_raddr = VIDX_W'(depth_q - CNT_W'(2));

  gdfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (adj_waddr),
    .wdata_i (adj_wdata),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gdfs_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VERTICES)) u_lbl_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.label_wr),
    .waddr_i (in_first),
    .wdata_i (in_label),
    .re_i    (lbl_re),
    .raddr_i (lbl_raddr),
    .rdata_o (lbl_rdata)
  );

  gdfs_ram #(.WIDTH(VIDX_W), .DEPTH(MAX_VERTICES)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= CNT_W'(MAX_VERTICES);
      adj_vld_q   <= '0;
      lbl_vld_q   <= '0;
      visited_q   <= '0;
      depth_q     <= '0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) vcount_q <= cfg_data_i;

      if (cmd_i.clear_adj) begin
        adj_vld_q <= '0;
      end else if (adj_we) begin
        adj_vld_q <= adj_vld_q | bit_of(adj_waddr);
      end

      if (cmd_i.label_wr) lbl_vld_q <= lbl_vld_q | bit_of(in_first);

      if (cmd_i.trav_start) begin
        visited_q  <= '0;
        depth_q    <= '0;
        emit_cnt_q <= '0;
      end else if (cmd_i.root_take) begin
        visited_q <= visited_q | bit_of(root_idx);
        depth_q   <= CNT_W'(1);
      end else if (cmd_i.cand_take) begin
        visited_q <= visited_q | bit_of(nx_idx);
        depth_q   <= depth_q + CNT_W'(1);
      end else if (cmd_i.pop) begin
        depth_q <= depth_q - CNT_W'(1);
      end

      if (cmd_i.emit) emit_cnt_q <= emit_cnt_q + CNT_W'(1);

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_start) begin
      a_q <= in_first;
      b_q <= in_second;
    end
    if (adj_re) adj_rvld_q <= adj_vld_q[adj_raddr];
    if (lbl_re) lbl_rvld_q <= lbl_vld_q[lbl_raddr];
    if (cmd_i.root_take) begin
      emit_idx_q <= root_idx;
    end else if (cmd_i.cand_take) begin
      emit_idx_q <= nx_idx;
    end
    if (cmd_i.emit) begin
      out_idx_q  <= emit_idx_q;
      out_lbl_q  <= lbl_val;
      // every active vertex is visited once, so the count marks the last beat
      out_last_q <= (CNT_W'(emit_cnt_q + CNT_W'(1)) == n_act);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(OUT_DATA_W-VIDX_W-LABEL_W){1'b0}}, out_lbl_q, out_idx_q};
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/gdfs_checker.sv =====
// Port-level checks of the DFS block, bound to its top level.
`default_nettype none

`include "graph_dfs_adjacency_matrix_assert.svh"

module gdfs_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [gdfs_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [gdfs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);
  import gdfs_pkg::*;

  // a stalled output beat stays offered
  `GDFS_ASSERT_RST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output beat dropped while stalled")

  // and keeps its payload
  `GDFS_ASSERT_RST(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output payload changed")

  // the walk is still running while a non-final vertex waits
  `GDFS_ASSERT_ALWAYS(a_busy_mid_run, clk_i, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready, "input taken in the middle of a traversal")

  // a traverse beat starts the walk and closes the input
  `GDFS_ASSERT_RST(a_trav_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_TRAVERSE) |=> !s_axis_tready, "input still ready after a traverse beat")

endmodule

bind graph_dfs_adjacency_matrix gdfs_checker u_gdfs_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the depth-first search block: predicts preorder beats and compares.
`default_nettype none

module testbench;
  import gdfs_pkg::*;

  localparam int WATCH_LIMIT = 3000;

  typedef struct {
    vidx_t  idx;
    label_t lab;
    logic   last;
  } visit_t;

  // Mirror of the graph state; works out the preorder of each traversal
  class dfs_scoreboard;
    row_t   adj[MAX_VERTICES];
    label_t labels[MAX_VERTICES];
    cnt_t   vcount;
    visit_t visits_q[$];
    int     errors;
    int     applied;

    function new();
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj[i] = '0;
        labels[i] = '0;
      end
      vcount = cnt_t'(MAX_VERTICES);
      errors = 0;
      applied = 0;
    endfunction

    function void set_count(cnt_t v);
      vcount = v;
    endfunction

    function void add_visit(vidx_t v);
      visit_t e;
      e.idx = v;
      e.lab = labels[v];
      e.last = 1'b0;
      visits_q.push_back(e);
    endfunction

    function void walk_graph(int n);
      row_t  mask;
      row_t  visited;
      row_t  cand;
      vidx_t stack[MAX_VERTICES];
      int    depth;
      int    emitted;
      vidx_t top;
      vidx_t nx;
      mask = (n >= MAX_VERTICES) ? '1 : ((row_t'(1) << n) - row_t'(1));
      visited = '0;
      emitted = 0;
      for (int root = 0; root < n; root++) begin
        if (visited[root]) continue;
        visited[root] = 1'b1;
        add_visit(vidx_t'(root));
        emitted++;
        stack[0] = vidx_t'(root);
        depth = 1;
        while (depth > 0) begin
          top = stack[depth-1];
          cand = adj[top] & mask & ~visited;
          if (cand != '0) begin
            // lowest unvisited neighbour
            nx = '0;
            for (int k = MAX_VERTICES - 1; k >= 0; k--)
              if (cand[k]) nx = vidx_t'(k);
            visited[nx] = 1'b1;
            add_visit(nx);
            emitted++;
            if (depth < MAX_VERTICES) begin
              stack[depth] = nx;
              depth++;
            end
          end else begin
            depth--;
          end
        end
      end
      if (emitted > 0) visits_q[visits_q.size()-1].last = 1'b1;
    endfunction

    function void note_item(mode_e m, vidx_t a, vidx_t b, label_t l);
      int n;
      n = (vcount > MAX_VERTICES) ? MAX_VERTICES : int'(vcount);
      applied++;
      case (m)
        MODE_CLEAR: begin
          for (int i = 0; i < MAX_VERTICES; i++) adj[i] = '0;
        end
        MODE_EDGE: begin
          if (a < n && b < n) begin
            adj[a][b] = 1'b1;
            adj[b][a] = 1'b1;
          end
        end
        MODE_LABEL: begin
          if (a < n) begin
            labels[a] = l;
          end
        end
        default: begin
          walk_graph(n);
        end
      endcase
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      visit_t want;
      if (visits_q.size() == 0) begin
        errors++;
        if (errors < 40)
          $display("%0t: unexpected vertex beat, expected none, actual idx %0d label %0d",
                   $time, data[5:0], data[13:6]);
        return;
      end
      want = visits_q.pop_front();
      if (data[5:0] !== want.idx) begin
        errors++;
        if (errors < 40)
          $display("%0t: vertex_index expected %0d actual %0d", $time, want.idx, data[5:0]);
      end
      if (data[13:6] !== want.lab) begin
        errors++;
        if (errors < 40)
          $display("%0t: vertex_label expected %0d actual %0d", $time, want.lab, data[13:6]);
      end
      if (last !== want.last) begin
        errors++;
        if (errors < 40)
          $display("%0t: last_in_run expected %0b actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [IN_USER_W-1:0]  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CNT_W-1:0]      cfg_data_i;

  dfs_scoreboard sb = new();
  bit calm;
  bit src_idle;
  bit sink_idle;
  int quiet_cycles;

  graph_dfs_adjacency_matrix u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result sink: random stall bursts while sink_idle is set, unless calm
  initial begin : sink
    int stall;
    stall = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle && !calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 15) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tlast);
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(mode_e m, vidx_t a, vidx_t b, label_t l);
    if (src_idle && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tuser  <= m;
    s_axis_tdata  <= {4'b0000, l, b, a};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(m, a, b, l);
  endtask

  // Drop valid, drain every pending beat, then wait until the block is back in idle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.visits_q.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_count(cnt_t v);
    settle();
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_count(v);
  endtask

  function automatic vidx_t pick_vertex(int n);
    if ($urandom_range(0, 7) == 0) return vidx_t'($urandom_range(0, 63));
    return vidx_t'($urandom_range(0, n - 1));
  endfunction

  initial begin
    int     n;
    int     r;
    int     j;
    int     phase;
    cnt_t   cnt;
    vidx_t  order[MAX_VERTICES];
    vidx_t  tmp;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= MODE_CLEAR;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    calm      = 1'b0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full graph at the reset count: extreme labels, self loop, edge to the top vertex
    send_item(MODE_LABEL, 6'd0, 6'd0, 8'hFF);
    send_item(MODE_LABEL, 6'd63, 6'd0, 8'h5A);
    send_item(MODE_LABEL, 6'd42, 6'd0, 8'h81);
    send_item(MODE_EDGE, 6'd0, 6'd63, 8'h00);
    send_item(MODE_EDGE, 6'd63, 6'd62, 8'h00);
    send_item(MODE_EDGE, 6'd5, 6'd5, 8'h00);
    send_item(MODE_EDGE, 6'd1, 6'd2, 8'h00);
    send_item(MODE_EDGE, 6'd40, 6'd1, 8'hFF);
    send_item(MODE_TRAVERSE, 6'd0, 6'd0, 8'h00);

    // Shrunk graph: out-of-range items ignored, stale edges not followed
    write_count(cnt_t'(3));
    send_item(MODE_LABEL, 6'd7, 6'd0, 8'h33);
    send_item(MODE_EDGE, 6'd2, 6'd5, 8'h00);
    send_item(MODE_EDGE, 6'd0, 6'd2, 8'h00);
    send_item(MODE_TRAVERSE, 6'd63, 6'd63, 8'hFF);

    write_count(cnt_t'(1));
    send_item(MODE_TRAVERSE, 6'd0, 6'd0, 8'h00);
    send_item(MODE_EDGE, 6'd0, 6'd0, 8'h00);
    send_item(MODE_TRAVERSE, 6'd0, 6'd0, 8'h00);

    // Zero count: nothing emitted, nothing stored
    write_count(cnt_t'(0));
    send_item(MODE_TRAVERSE, 6'd0, 6'd0, 8'h00);
    send_item(MODE_LABEL, 6'd0, 6'd0, 8'h11);

    // Count past the maximum clamps to the full matrix
    write_count(cnt_t'(127));
    send_item(MODE_CLEAR, 6'd63, 6'd63, 8'hFF);
    send_item(MODE_TRAVERSE, 6'd0, 6'd0, 8'h00);

    phase = 0;
    while (sb.applied < 270) begin
      if (sb.applied >= 215) calm = 1'b1;
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 9);
      if (phase == 2) cnt = cnt_t'(64);
      else if (r < 5) cnt = cnt_t'($urandom_range(1, 12));
      else if (r < 8) cnt = cnt_t'($urandom_range(13, 64));
      else if (r == 8) cnt = cnt_t'(64);
      else cnt = cnt_t'($urandom_range(65, 127));
      write_count(cnt);
      n = (cnt > MAX_VERTICES) ? MAX_VERTICES : int'(cnt);

      if (phase == 2) begin
        // Hamiltonian path in random order drives the stack deep, to full depth when vertex 0 ends the path
        for (int i = 0; i < MAX_VERTICES; i++) order[i] = vidx_t'(i);
        for (int i = MAX_VERTICES - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = order[i];
          order[i] = order[j];
          order[j] = tmp;
        end
        send_item(MODE_CLEAR, vidx_t'($urandom), vidx_t'($urandom), label_t'($urandom));
        for (int i = 0; i < MAX_VERTICES - 1; i++)
          send_item(MODE_EDGE, order[i], order[i+1], label_t'($urandom));
      end else begin
        if ($urandom_range(0, 2) != 0)
          send_item(MODE_CLEAR, vidx_t'($urandom), vidx_t'($urandom), label_t'($urandom));
        repeat ($urandom_range(0, (2 * n > 24) ? 24 : 2 * n))
          send_item(MODE_EDGE, pick_vertex(n), pick_vertex(n), label_t'($urandom));
        repeat ($urandom_range(0, 4))
          send_item(MODE_LABEL, pick_vertex(n), vidx_t'($urandom), label_t'($urandom));
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3))
            send_item(mode_e'($urandom_range(0, 3)), vidx_t'($urandom),
                      vidx_t'($urandom), label_t'($urandom));
      end
      send_item(MODE_TRAVERSE, vidx_t'($urandom), vidx_t'($urandom), label_t'($urandom));
      if ($urandom_range(0, 5) == 0)
        send_item(MODE_TRAVERSE, vidx_t'($urandom), vidx_t'($urandom), label_t'($urandom));
      phase++;
    end

    settle();
    if (sb.visits_q.size() != 0)
      $display("%0t: %0d expected vertex beats never arrived", $time, sb.visits_q.size());
    if (sb.errors == 0 && sb.visits_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
